// ----- rtl/tep_pkg.sv -----
// ----------------------------------------------------------------------------
// Touch event to pointer: shared types and constants
// Event codes, result kinds, register indexes and state types used by the
// sequencer and the coordinate scaler.
// ----------------------------------------------------------------------------
package tep_pkg;

  localparam logic [4:0] EV_SYN = 5'd0;
  localparam logic [4:0] EV_KEY = 5'd1;
  localparam logic [4:0] EV_ABS = 5'd3;

  localparam logic [9:0] SYNC_FRAME     = 10'h000;
  localparam logic [9:0] ABS_X          = 10'h000;
  localparam logic [9:0] ABS_Y          = 10'h001;
  localparam logic [9:0] ABS_MT_X       = 10'h035;
  localparam logic [9:0] ABS_MT_Y       = 10'h036;
  localparam logic [9:0] ABS_MT_TRACKID = 10'h039;
  localparam logic [9:0] KEY_TOUCH      = 10'h14A;

  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_MOVE    = 2'd2;

  localparam logic [2:0] REG_X_MIN  = 3'd0;
  localparam logic [2:0] REG_X_MAX  = 3'd1;
  localparam logic [2:0] REG_Y_MIN  = 3'd2;
  localparam logic [2:0] REG_Y_MAX  = 3'd3;
  localparam logic [2:0] REG_SCR_W  = 3'd4;
  localparam logic [2:0] REG_SCR_H  = 3'd5;

  localparam int SCR_W  = 12;
  localparam int POS_W  = 31;
  localparam int PROD_W = 32 + SCR_W;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [SCR_W-1:0]   scr;
  } scl_req_t;

  typedef enum logic [1:0] {
    SCL_IDLE,
    SCL_MUL,
    SCL_DIV
  } scl_state_t;

  typedef enum logic [2:0] {
    TEP_IDLE,
    TEP_X,
    TEP_XW,
    TEP_Y,
    TEP_YW,
    TEP_EMIT
  } tep_state_t;

endpackage

// ----- rtl/tep_scaler.sv -----
// ----------------------------------------------------------------------------
// Touch event to pointer: coordinate scaler
// Maps one raw coordinate v to (v-min)*screen/(max-min) pixels, clamped to
// 0..screen-1 (v if max <= min or screen is 0), by multiply and bit-serial divide.
// ----------------------------------------------------------------------------
module tep_scaler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  tep_pkg::scl_req_t               req,
  output logic                            done,
  output logic [tep_pkg::POS_W-1:0]       result
);
  import tep_pkg::*;

  scl_state_t        state, state_next;
  logic [31:0]       diff;
  logic [31:0]       span;
  logic [SCR_W-1:0]  scr;
  logic [31:0]       rem;
  logic [SCR_W-1:0]  shf;
  logic [3:0]        cnt;
  logic [32:0]       diff_full, span_full;
  logic [PROD_W-1:0] prod;
  logic [32:0]       rem2;
  logic              qbit;
  logic              degenerate;

  assign diff_full  = {req.value[31], req.value} - {req.lo[31], req.lo};
  assign span_full  = {req.hi[31], req.hi} - {req.lo[31], req.lo};
  assign degenerate = (req.hi <= req.lo) || (req.scr == '0);
  assign prod       = PROD_W'(diff) * PROD_W'(scr);
  assign rem2       = {rem, shf[SCR_W-1]};
  assign qbit       = rem2 >= {1'b0, span};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SCL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SCL_IDLE: begin
        if (start && !degenerate && !(req.value < req.lo) && !(req.value >= req.hi)) begin
          state_next = SCL_MUL;
        end
      end
      SCL_MUL: state_next = SCL_DIV;
      SCL_DIV: begin
        if (cnt == 4'(SCR_W - 1)) begin
          state_next = SCL_IDLE;
        end
      end
      default: state_next = SCL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        SCL_IDLE: begin
          if (start) begin
            if (degenerate) begin
              result <= req.value[POS_W-1:0];
              done   <= 1'b1;
            end else if (req.value < req.lo) begin
              result <= '0;
              done   <= 1'b1;
            end else if (req.value >= req.hi) begin
              result <= POS_W'(req.scr - SCR_W'(1));
              done   <= 1'b1;
            end
          end
        end
        SCL_MUL: begin
          rem <= prod[PROD_W-1:SCR_W];
          shf <= prod[SCR_W-1:0];
          cnt <= '0;
        end
        SCL_DIV: begin
          rem <= qbit ? 32'(rem2 - {1'b0, span}) : rem2[31:0];
          shf <= {shf[SCR_W-2:0], qbit};
          cnt <= cnt + 4'd1;
          if (cnt == 4'(SCR_W - 1)) begin
            result <= POS_W'({shf[SCR_W-2:0], qbit});
            done   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == SCL_IDLE && start) begin
      diff <= diff_full[31:0];
      span <= span_full[31:0];
      scr  <= req.scr;
    end
  end

endmodule

// ----- rtl/touch_event_to_pointer_top.sv -----
// ----------------------------------------------------------------------------
// Touch event to pointer: top level
// Tracks touch state from input events and, on each sync report, scales the
// captured coordinates and sends press, release and move results.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// s_*      in         input event request: tdata = type, code, value
// m_*      out        pointer result request: tdata = kind, x, y; tlast ends run
// cfg_*    in         register write: index, data
//
// Non-sync events are handled in the idle state. On a sync report each captured
// axis runs through the shared scaler (a multiply state and a 12-step divider)
// and the results enter the output register one at a time; input is held off
// until all have entered it, which an output stall only delays. Reset is
// synchronous; all registers but output data and scaler datapath are restored.
// ----------------------------------------------------------------------------
module touch_event_to_pointer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // event_type[4:0], event_code[14:5], event_value[46:15]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // event_kind[1:0], pos_x[32:2], pos_y[63:33]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tep_pkg::*;

  tep_state_t         state, state_next;
  logic signed [31:0] x_min, x_max, y_min, y_max;
  logic [SCR_W-1:0]   scr_w, scr_h;
  logic               touching, pending_press, pending_release;
  logic signed [31:0] captured_x, captured_y;
  logic [POS_W-1:0]   position_x, position_y;
  logic               have_x, have_y;
  logic               emit_press, emit_release, emit_move;
  logic [1:0]         out_kind;
  logic [POS_W-1:0]   out_x, out_y;
  logic               accept;
  logic [4:0]         ev_type;
  logic [9:0]         ev_code;
  logic signed [31:0] ev_value;
  logic               scl_start, scl_done;
  logic [POS_W-1:0]   scl_result;
  scl_req_t           scl_req;
  logic               out_free;

  assign ev_type  = s_tdata[4:0];
  assign ev_code  = s_tdata[14:5];
  assign ev_value = s_tdata[46:15];
  assign s_tready = (state == TEP_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {out_y, out_x, out_kind};
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    if (state == TEP_X) begin
      scl_req = '{value: captured_x, lo: x_min, hi: x_max, scr: scr_w};
    end else begin
      scl_req = '{value: captured_y, lo: y_min, hi: y_max, scr: scr_h};
    end
  end

  tep_scaler u_scaler (
    .clk    (clk),
    .rst    (rst),
    .start  (scl_start),
    .req    (scl_req),
    .done   (scl_done),
    .result (scl_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TEP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    scl_start  = 1'b0;
    unique case (state)
      TEP_IDLE: begin
        if (accept && ev_type == EV_SYN && ev_code == SYNC_FRAME) begin
          state_next = TEP_X;
        end
      end
      TEP_X: begin
        if (have_x) begin
          scl_start  = 1'b1;
          state_next = TEP_XW;
        end else begin
          state_next = TEP_Y;
        end
      end
      TEP_XW: begin
        if (scl_done) begin
          state_next = TEP_Y;
        end
      end
      TEP_Y: begin
        if (have_y) begin
          scl_start  = 1'b1;
          state_next = TEP_YW;
        end else begin
          state_next = TEP_EMIT;
        end
      end
      TEP_YW: begin
        if (scl_done) begin
          state_next = TEP_EMIT;
        end
      end
      TEP_EMIT: begin
        if (!emit_press && !emit_release && !emit_move) begin
          state_next = TEP_IDLE;
        end
      end
      default: state_next = TEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min           <= 32'sd0;
      x_max           <= 32'sd1;
      y_min           <= 32'sd0;
      y_max           <= 32'sd1;
      scr_w           <= '0;
      scr_h           <= '0;
      touching        <= 1'b0;
      pending_press   <= 1'b0;
      pending_release <= 1'b0;
      captured_x      <= -32'sd1;
      captured_y      <= -32'sd1;
      position_x      <= '0;
      position_y      <= '0;
      have_x          <= 1'b0;
      have_y          <= 1'b0;
      emit_press      <= 1'b0;
      emit_release    <= 1'b0;
      emit_move       <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_X_MIN: x_min <= cfg_data;
          REG_X_MAX: x_max <= cfg_data;
          REG_Y_MIN: y_min <= cfg_data;
          REG_Y_MAX: y_max <= cfg_data;
          REG_SCR_W: scr_w <= cfg_data[SCR_W-1:0];
          REG_SCR_H: scr_h <= cfg_data[SCR_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        if (ev_type == EV_ABS) begin
          if (ev_code == ABS_X || ev_code == ABS_MT_X) begin
            captured_x <= ev_value;
          end else if (ev_code == ABS_Y || ev_code == ABS_MT_Y) begin
            captured_y <= ev_value;
          end else if (ev_code == ABS_MT_TRACKID) begin
            if (ev_value < 0) begin
              if (touching) begin
                touching        <= 1'b0;
                pending_release <= 1'b1;
              end
            end else if (!touching) begin
              touching      <= 1'b1;
              pending_press <= 1'b1;
            end
          end
        end else if (ev_type == EV_KEY && ev_code == KEY_TOUCH) begin
          if (ev_value != 0) begin
            if (!touching) begin
              touching      <= 1'b1;
              pending_press <= 1'b1;
            end
          end else if (touching) begin
            touching        <= 1'b0;
            pending_release <= 1'b1;
          end
        end else if (ev_type == EV_SYN && ev_code == SYNC_FRAME) begin
          have_x          <= !captured_x[31];
          have_y          <= !captured_y[31];
          emit_press      <= pending_press;
          emit_release    <= pending_release;
          emit_move       <= (!captured_x[31] || !captured_y[31]) && touching;
          pending_press   <= 1'b0;
          pending_release <= 1'b0;
        end
      end

      if (state == TEP_EMIT) begin
        captured_x <= -32'sd1;
        captured_y <= -32'sd1;
      end

      if (state == TEP_XW && scl_done) begin
        position_x <= scl_result;
      end
      if (state == TEP_YW && scl_done) begin
        position_y <= scl_result;
      end

      if (state == TEP_EMIT && out_free && (emit_press || emit_release || emit_move)) begin
        m_tvalid <= 1'b1;
        if (emit_press) begin
          out_kind   <= KIND_PRESS;
          out_x      <= '0;
          out_y      <= '0;
          m_tlast    <= !emit_release && !emit_move;
          emit_press <= 1'b0;
        end else if (emit_release) begin
          out_kind     <= KIND_RELEASE;
          out_x        <= '0;
          out_y        <= '0;
          m_tlast      <= !emit_move;
          emit_release <= 1'b0;
        end else begin
          out_kind  <= KIND_MOVE;
          out_x     <= position_x;
          out_y     <= position_y;
          m_tlast   <= 1'b1;
          emit_move <= 1'b0;
        end
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ----- test/touch_event_to_pointer_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch event to pointer: self-checking block test
// Feeds input events into the block, first from a directed table and then as
// random touch frames with noise, under several axis and screen settings. An
// internal tracker predicts the press, release and move results, apart from the
// typed ones of directed rows, and the output monitor compares each result
// field by field in order.
module touch_event_to_pointer_top_test;
  import tep_pkg::*;

  localparam int ITEMS_RANDOM  = 220;
  localparam int SETTLE_CYCLES = 48;
  localparam int QUIET_LIMIT   = 2000;

  localparam logic [2:0] REG_SPARE_6     = 3'd6;
  localparam logic [2:0] REG_SPARE_7     = 3'd7;
  localparam logic [9:0] CODE_SYN_OTHER  = 10'h001;
  localparam logic [9:0] CODE_KEY_OTHER  = 10'h110;
  localparam logic [9:0] CODE_ABS_OTHER  = 10'h3FF;
  localparam logic [4:0] TYPE_OTHER      = 5'h1F;
  localparam longint     S32_MAX         = 64'sd2147483647;
  localparam longint     S32_MIN         = -64'sd2147483648;

  typedef struct packed {
    logic [1:0]  kind;
    logic [30:0] px;
    logic [30:0] py;
    logic        last;
  } ptr_res_t;

  typedef enum logic [1:0] {
    ROW_TYPED,
    ROW_PRED,
    ROW_CFG
  } row_op_t;

  typedef struct packed {
    row_op_t     op;
    logic [2:0]  reg_idx;
    logic [4:0]  ev_type;
    logic [9:0]  ev_code;
    logic [31:0] ev_value;
    logic [1:0]  n_typed;
    ptr_res_t    r0;
    ptr_res_t    r1;
  } stim_row_t;

  localparam ptr_res_t RES_NONE    = '0;
  localparam ptr_res_t PRESS_MID   = '{KIND_PRESS, 31'd0, 31'd0, 1'b0};
  localparam ptr_res_t RELEASE_END = '{KIND_RELEASE, 31'd0, 31'd0, 1'b1};
  localparam ptr_res_t MOVE_TOP_X  = '{KIND_MOVE, 31'h7FFF_FFFF, 31'd0, 1'b1};
  localparam ptr_res_t MOVE_Y_1234 = '{KIND_MOVE, 31'h7FFF_FFFF, 31'd1234, 1'b1};

  localparam int N_DIR = 37;
  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    '{ROW_TYPED, '0, EV_KEY, KEY_TOUCH, 32'd1, 2'd0, RES_NONE, RES_NONE},
    '{ROW_TYPED, '0, EV_ABS, ABS_X, 32'h7FFF_FFFF, 2'd0, RES_NONE, RES_NONE},
    '{ROW_TYPED, '0, EV_ABS, ABS_Y, 32'd0, 2'd0, RES_NONE, RES_NONE},
    '{ROW_TYPED, '0, EV_SYN, SYNC_FRAME, 32'd0, 2'd2, PRESS_MID, MOVE_TOP_X},
    '{ROW_TYPED, '0, EV_ABS, ABS_MT_X, 32'h8000_0000, 2'd0, RES_NONE, RES_NONE},
    '{ROW_TYPED, '0, EV_SYN, SYNC_FRAME, 32'd0, 2'd0, RES_NONE, RES_NONE},
    '{ROW_TYPED, '0, EV_ABS, ABS_MT_Y, 32'd1234, 2'd0, RES_NONE, RES_NONE},
    '{ROW_TYPED, '0, EV_SYN, SYNC_FRAME, 32'd0, 2'd1, MOVE_Y_1234, RES_NONE},
    '{ROW_TYPED, '0, EV_KEY, KEY_TOUCH, 32'hFFFF_FFFF, 2'd0, RES_NONE, RES_NONE},
    '{ROW_TYPED, '0, EV_ABS, ABS_MT_TRACKID, 32'd7, 2'd0, RES_NONE, RES_NONE},
    '{ROW_TYPED, '0, EV_ABS, ABS_MT_TRACKID, 32'hFFFF_FFFF, 2'd0, RES_NONE, RES_NONE},
    '{ROW_TYPED, '0, EV_ABS, ABS_MT_TRACKID, 32'h8000_0000, 2'd0, RES_NONE, RES_NONE},
    '{ROW_TYPED, '0, EV_ABS, ABS_X, 32'd10, 2'd0, RES_NONE, RES_NONE},
    '{ROW_TYPED, '0, EV_SYN, SYNC_FRAME, 32'd0, 2'd1, RELEASE_END, RES_NONE},
    '{ROW_TYPED, '0, EV_KEY, KEY_TOUCH, 32'd1, 2'd0, RES_NONE, RES_NONE},
    '{ROW_TYPED, '0, EV_KEY, KEY_TOUCH, 32'd0, 2'd0, RES_NONE, RES_NONE},
    '{ROW_TYPED, '0, EV_SYN, SYNC_FRAME, 32'd0, 2'd2, PRESS_MID, RELEASE_END},
    '{ROW_TYPED, '0, EV_SYN, CODE_SYN_OTHER, 32'hFFFF_FFFF, 2'd0, RES_NONE, RES_NONE},
    '{ROW_TYPED, '0, TYPE_OTHER, CODE_ABS_OTHER, 32'hFFFF_FFFF, 2'd0, RES_NONE, RES_NONE},
    '{ROW_TYPED, '0, EV_KEY, CODE_KEY_OTHER, 32'd1, 2'd0, RES_NONE, RES_NONE},
    '{ROW_TYPED, '0, EV_ABS, CODE_ABS_OTHER, 32'd5, 2'd0, RES_NONE, RES_NONE},
    '{ROW_CFG, REG_X_MIN, '0, '0, 32'd100, 2'd0, RES_NONE, RES_NONE},
    '{ROW_CFG, REG_X_MAX, '0, '0, 32'd1100, 2'd0, RES_NONE, RES_NONE},
    '{ROW_CFG, REG_Y_MIN, '0, '0, 32'h8000_0000, 2'd0, RES_NONE, RES_NONE},
    '{ROW_CFG, REG_Y_MAX, '0, '0, 32'h7FFF_FFFF, 2'd0, RES_NONE, RES_NONE},
    '{ROW_CFG, REG_SCR_W, '0, '0, 32'hFFFF_FFFF, 2'd0, RES_NONE, RES_NONE},
    '{ROW_CFG, REG_SCR_H, '0, '0, 32'd1, 2'd0, RES_NONE, RES_NONE},
    '{ROW_CFG, REG_SPARE_6, '0, '0, 32'hFFFF_FFFF, 2'd0, RES_NONE, RES_NONE},
    '{ROW_CFG, REG_SPARE_7, '0, '0, 32'd0, 2'd0, RES_NONE, RES_NONE},
    '{ROW_PRED, '0, EV_ABS, ABS_MT_TRACKID, 32'd3, 2'd0, RES_NONE, RES_NONE},
    '{ROW_PRED, '0, EV_ABS, ABS_MT_X, 32'd50, 2'd0, RES_NONE, RES_NONE},
    '{ROW_PRED, '0, EV_ABS, ABS_MT_Y, 32'h7FFF_FFFF, 2'd0, RES_NONE, RES_NONE},
    '{ROW_PRED, '0, EV_SYN, SYNC_FRAME, 32'd0, 2'd0, RES_NONE, RES_NONE},
    '{ROW_PRED, '0, EV_ABS, ABS_MT_TRACKID, 32'hFFFF_FFFF, 2'd0, RES_NONE, RES_NONE},
    '{ROW_PRED, '0, EV_ABS, ABS_MT_TRACKID, 32'd0, 2'd0, RES_NONE, RES_NONE},
    '{ROW_PRED, '0, EV_ABS, ABS_MT_X, 32'd5000, 2'd0, RES_NONE, RES_NONE},
    '{ROW_PRED, '0, EV_SYN, SYNC_FRAME, 32'd0, 2'd0, RES_NONE, RES_NONE}
  };

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata   = '0;   // event_type[4:0], event_code[14:5], event_value[46:15]
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [63:0] m_tdata;          // event_kind[1:0], pos_x[32:2], pos_y[63:33]
  logic        m_tlast;          // last_of_run
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  // Tracker copy of the block's state and registers.
  logic signed [31:0] x_lo = 32'sd0;
  logic signed [31:0] x_hi = 32'sd1;
  logic signed [31:0] y_lo = 32'sd0;
  logic signed [31:0] y_hi = 32'sd1;
  logic [11:0]        width_px  = '0;
  logic [11:0]        height_px = '0;
  logic               finger_down = 1'b0;
  logic               press_due   = 1'b0;
  logic               release_due = 1'b0;
  logic signed [31:0] raw_x = -32'sd1;
  logic signed [31:0] raw_y = -32'sd1;
  logic [30:0]        last_x = '0;
  logic [30:0]        last_y = '0;

  ptr_res_t frame_out [3];
  ptr_res_t pointer_q [$];

  bit src_idle = 1'b1;
  bit snk_idle = 1'b1;
  int fails      = 0;
  int n_items    = 0;
  int n_results  = 0;
  int n_moves    = 0;
  int n_settings = 1;
  int quiet      = 0;

  touch_event_to_pointer_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [30:0] map_coord(input logic signed [31:0] v,
                                            input logic signed [31:0] lo,
                                            input logic signed [31:0] hi,
                                            input logic [11:0] scr);
    longint span;
    longint q;
    if (hi <= lo || scr == 12'd0) return v[30:0];
    span = longint'(hi) - longint'(lo);
    q = ((longint'(v) - longint'(lo)) * longint'(scr)) / span;
    if (q < 0) q = 0;
    if (q >= longint'(scr)) q = longint'(scr) - 1;
    return q[30:0];
  endfunction

  function automatic void set_touch(input bit on);
    if (on && !finger_down) begin
      finger_down = 1'b1;
      press_due   = 1'b1;
    end else if (!on && finger_down) begin
      finger_down = 1'b0;
      release_due = 1'b1;
    end
  endfunction

  // Applies one event to the tracker; returns the number of results in frame_out.
  function automatic int track_event(input logic [4:0] typ, input logic [9:0] code,
                                     input logic signed [31:0] val);
    int n;
    bit have_x;
    bit have_y;
    n = 0;
    if (typ == EV_ABS) begin
      if (code == ABS_X || code == ABS_MT_X) raw_x = val;
      else if (code == ABS_Y || code == ABS_MT_Y) raw_y = val;
      else if (code == ABS_MT_TRACKID) set_touch(val >= 0);
    end else if (typ == EV_KEY) begin
      if (code == KEY_TOUCH) set_touch(val != 0);
    end else if (typ == EV_SYN && code == SYNC_FRAME) begin
      have_x = !raw_x[31];
      have_y = !raw_y[31];
      if (have_x) last_x = map_coord(raw_x, x_lo, x_hi, width_px);
      if (have_y) last_y = map_coord(raw_y, y_lo, y_hi, height_px);
      if (press_due) begin
        press_due = 1'b0;
        frame_out[n] = '{KIND_PRESS, 31'd0, 31'd0, 1'b0};
        n++;
      end
      if (release_due) begin
        release_due = 1'b0;
        frame_out[n] = '{KIND_RELEASE, 31'd0, 31'd0, 1'b0};
        n++;
      end
      if ((have_x || have_y) && finger_down) begin
        frame_out[n] = '{KIND_MOVE, last_x, last_y, 1'b0};
        n++;
      end
      if (n > 0) frame_out[n-1].last = 1'b1;
      raw_x = -32'sd1;
      raw_y = -32'sd1;
    end
    return n;
  endfunction

  function automatic stim_row_t pred_row(input logic [4:0] t, input logic [9:0] c,
                                         input logic [31:0] v);
    stim_row_t r;
    r = '0;
    r.op       = ROW_PRED;
    r.ev_type  = t;
    r.ev_code  = c;
    r.ev_value = v;
    return r;
  endfunction

  function automatic logic [31:0] axis_value(input logic signed [31:0] lo,
                                             input logic signed [31:0] hi);
    longint span;
    longint v;
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) return $urandom;
    if (hi <= lo) return $urandom_range(0, 5000);
    span = longint'(hi) - longint'(lo);
    v = longint'(lo) + longint'(r % (span + 1));
    if ($urandom_range(0, 4) == 0) v = v + longint'($urandom_range(0, 2000)) - 1000;
    if (v > S32_MAX) v = S32_MAX;
    if (v < S32_MIN) v = S32_MIN;
    return v[31:0];
  endfunction

  task automatic pick_range(output logic [31:0] lo, output logic [31:0] hi);
    int base;
    case ($urandom_range(0, 4))
      0: begin
        base = int'($urandom_range(0, 4000)) - 2000;
        lo = base;
        hi = base + int'($urandom_range(1, 60000));
      end
      1: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
      end
      2: begin
        lo = $urandom;
        hi = lo;
      end
      3: begin
        base = int'($urandom_range(0, 4000));
        lo = base;
        hi = base - int'($urandom_range(1, 900));
      end
      default: begin
        lo = $urandom;
        hi = $urandom;
      end
    endcase
  endtask

  function automatic logic [11:0] pick_screen();
    case ($urandom_range(0, 3))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'd1;
      default: return 12'($urandom_range(2, 4094));
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pointer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_X_MIN: x_lo = data;
      REG_X_MAX: x_hi = data;
      REG_Y_MIN: y_lo = data;
      REG_Y_MAX: y_hi = data;
      REG_SCR_W: width_px = data[11:0];
      REG_SCR_H: height_px = data[11:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_event(input stim_row_t row, input bit counted);
    int n;
    if (src_idle && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11) - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, row.ev_value, row.ev_code, row.ev_type};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n = track_event(row.ev_type, row.ev_code, row.ev_value);
    if (row.op == ROW_TYPED) begin
      if (row.n_typed > 0) pointer_q.push_back(row.r0);
      if (row.n_typed > 1) pointer_q.push_back(row.r1);
    end else begin
      for (int k = 0; k < n; k++) pointer_q.push_back(frame_out[k]);
    end
    if (counted) n_items++;
  endtask

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    ptr_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pointer_q.size() == 0) begin
        $error("pointer result with none expected: kind %0d, x %0d, y %0d",
               m_tdata[1:0], m_tdata[32:2], m_tdata[63:33]);
        fails++;
      end else begin
        want = pointer_q.pop_front();
        check_field("event_kind", want.kind, m_tdata[1:0]);
        check_field("pos_x", want.px, m_tdata[32:2]);
        check_field("pos_y", want.py, m_tdata[63:33]);
        check_field("last_of_run", want.last, m_tlast);
        n_results++;
        if (want.kind == KIND_MOVE) n_moves++;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $error("no request accepted for %0d cycles, %0d results outstanding",
             quiet, pointer_q.size());
      $display("touch_event_to_pointer_top_test NOT OK");
      $finish;
    end
  end

  initial begin
    int hold;
    forever begin
      @(negedge clk);
      if (snk_idle && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        hold = $urandom_range(1, 11);
        repeat (hold) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  initial begin
    int phase;
    int n_dir;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] v;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].op == ROW_CFG) begin
        write_reg(DIR_ROWS[i].reg_idx, DIR_ROWS[i].ev_value);
      end else begin
        send_event(DIR_ROWS[i], 1'b1);
      end
    end
    n_settings++;
    n_dir = n_items;

    // Mostly well-formed frames: touch changes, captures, then a sync report.
    phase = 0;
    while (n_items < n_dir + ITEMS_RANDOM) begin
      src_idle = (n_items < n_dir + 170) && (phase % 3 != 2);
      snk_idle = (n_items < n_dir + 170) && (phase % 4 != 1);
      pick_range(lo, hi);
      write_reg(REG_X_MIN, lo);
      write_reg(REG_X_MAX, hi);
      pick_range(lo, hi);
      write_reg(REG_Y_MIN, lo);
      write_reg(REG_Y_MAX, hi);
      write_reg(REG_SCR_W, {20'($urandom), pick_screen()});
      write_reg(REG_SCR_H, {20'($urandom), pick_screen()});
      n_settings++;
      repeat (12) begin
        repeat ($urandom_range(0, 2)) begin
          if ($urandom_range(0, 1) != 0) begin
            case ($urandom_range(0, 2))
              0: v = $urandom;
              1: v = 32'hFFFF_FFFF;
              default: v = $urandom_range(0, 100);
            endcase
            send_event(pred_row(EV_ABS, ABS_MT_TRACKID, v), 1'b1);
          end else begin
            case ($urandom_range(0, 2))
              0: v = 32'd0;
              1: v = 32'd1;
              default: v = $urandom;
            endcase
            send_event(pred_row(EV_KEY, KEY_TOUCH, v), 1'b1);
          end
        end
        if ($urandom_range(0, 9) < 7)
          send_event(pred_row(EV_ABS, ($urandom_range(0, 1) != 0) ? ABS_X : ABS_MT_X,
                              axis_value(x_lo, x_hi)), 1'b1);
        if ($urandom_range(0, 9) < 7)
          send_event(pred_row(EV_ABS, ($urandom_range(0, 1) != 0) ? ABS_Y : ABS_MT_Y,
                              axis_value(y_lo, y_hi)), 1'b1);
        if ($urandom_range(0, 9) < 3)
          send_event(pred_row(5'($urandom), 10'($urandom), $urandom), 1'b0);
        if ($urandom_range(0, 9) != 0)
          send_event(pred_row(EV_SYN, SYNC_FRAME, $urandom), 1'b1);
      end
      phase++;
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pointer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d touch events (%0d directed) across %0d register settings.",
             n_items, n_dir, n_settings);
    $display("Checked %0d pointer results, %0d of them moves; %0d mismatches.",
             n_results, n_moves, fails);
    if (fails == 0) begin
      $display("touch_event_to_pointer_top_test OK");
    end else begin
      $display("touch_event_to_pointer_top_test NOT OK");
    end
    $finish;
  end

endmodule
